FILE: hdl/pps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int TICK_W = 32;
    localparam int TIME_W = 16;
    localparam int PRIO_W = 8;
    localparam int PORT_SLOT_W = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // one task slot as held in the slot memory
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] remaining;
        logic              started;
    } entry_t;

    // control from the sequencer to the pick unit
    typedef struct packed {
        logic clear;
        logic cand_vld;
    } pick_ctl_t;

    // winner of a scan
    typedef struct packed {
        logic   found;
        entry_t entry;
    } pick_res_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EXEC  = 5'b10000
    } state_t;

endpackage

FILE: hdl/pps_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pick
// Running winner of a slot scan: lowest priority number, then earliest
// arrival; candidates arrive in ascending slot order so the lowest slot
// keeps a full tie.
// ----------------------------------------------------------------------------
module pps_pick #(
    parameter int SLOT_W = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pps_pkg::pick_ctl_t  ctl,
    input  logic [SLOT_W-1:0]   cand_idx,
    input  pps_pkg::entry_t     cand,
    output pps_pkg::pick_res_t  best,
    output logic [SLOT_W-1:0]   best_idx
);

    logic              found_reg;
    logic              found_next;
    pps_pkg::entry_t   entry_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              take;

    always_comb
    begin
        take = ctl.cand_vld &&
               (!found_reg ||
                (cand.prio < entry_reg.prio) ||
                ((cand.prio == entry_reg.prio) && (cand.arrival < entry_reg.arrival)));
        found_next = found_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !ctl.clear)
        begin
            entry_reg <= cand;
            idx_reg   <= cand_idx;
        end
    end

    assign best.found = found_reg;
    assign best.entry = entry_reg;
    assign best_idx   = idx_reg;

endmodule

FILE: hdl/preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Task slot table with priority pick, optional time quantum and tick counter.
// ----------------------------------------------------------------------------
// A load beat passes through the load state into the output register; a
// tick beat passes through the scan, drain and exec states into it. In both
// cases the next beat can be taken in the same cycle as the result shows.
// The slot memory has a single read port, so the winner search reads one
// slot per cycle, the drain state covers the read latency, and the exec
// state updates the winner and writes it back. One beat is in work at a
// time; the next beat is accepted while a result still waits in the output
// register, and a finished beat waits in its last state until the output
// register is free. Slot payload lives in a synchronous memory; only a
// pending bit per slot is kept in flops, so no clearing pass is needed
// after reset.
module preemptive_priority_scheduler #(
    parameter int NUM_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [3:0]  slot,
    input  logic [15:0] arrival,
    input  logic [15:0] duration,
    input  logic [7:0]  priority_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] tick_now,
    output logic        running_valid,
    output logic [3:0]  running_slot,
    output logic        first_run,
    output logic        new_slice,
    output logic        finished,
    output logic        all_done
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    // control state
    pps_pkg::state_t                 state_reg, state_next;
    logic [NUM_SLOTS-1:0]            pend_reg, pend_next;   // valid and not done
    logic [SLOT_W-1:0]               cur_slot_reg, cur_slot_next;
    logic                            cur_valid_reg, cur_valid_next;
    logic [15:0]                     qcount_reg, qcount_next;
    logic [31:0]                     tick_reg, tick_next;
    logic [15:0]                     quantum_reg;
    logic [SLOT_W-1:0]               scan_reg, scan_next;
    logic                            rd_vld_reg;
    logic                            out_valid_reg, out_valid_next;

    // captured beat
    logic [3:0]                      slot_reg;
    logic [15:0]                     arrival_reg;
    logic [15:0]                     duration_reg;
    logic [7:0]                      prio_reg;

    // result payload
    logic [31:0]                     o_tick_reg, o_tick_next;
    logic                            o_run_reg, o_run_next;
    logic [3:0]                      o_slot_reg, o_slot_next;
    logic                            o_first_reg, o_first_next;
    logic                            o_slice_reg, o_slice_next;
    logic                            o_fin_reg, o_fin_next;
    logic                            o_done_reg, o_done_next;

    // slot memory
    pps_pkg::entry_t                 mem [NUM_SLOTS];
    pps_pkg::entry_t                 rd_data_reg;
    logic [SLOT_W-1:0]               rd_idx_reg;
    logic                            mem_we, mem_re;
    logic [SLOT_W-1:0]               mem_waddr;
    pps_pkg::entry_t                 mem_wdata;

    // pick unit
    pps_pkg::pick_ctl_t              pick_ctl;
    pps_pkg::pick_res_t              best;
    logic [SLOT_W-1:0]               best_idx;

    logic                            accept;
    logic                            out_free;
    logic                            arr_ok;
    logic [SLOT_W-1:0]               ld_idx;
    logic                            ld_in_range;
    logic                            slice;
    logic [15:0]                     rem_dec;
    logic [15:0]                     qc_base;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == pps_pkg::ST_IDLE);

    assign ld_idx      = SLOT_W'(slot_reg);
    assign ld_in_range = (32'(slot_reg) < NUM_SLOTS);

    // arrival is 16 bits, tick is 32
    assign arr_ok = (tick_reg[31:16] != 16'd0) || (rd_data_reg.arrival <= tick_reg[15:0]);

    assign pick_ctl.clear    = accept;
    assign pick_ctl.cand_vld = rd_vld_reg && pend_reg[rd_idx_reg] && arr_ok;

    pps_pick #(
        .SLOT_W (SLOT_W)
    ) u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (pick_ctl),
        .cand_idx (rd_idx_reg),
        .cand     (rd_data_reg),
        .best     (best),
        .best_idx (best_idx)
    );

    always_comb
    begin
        slice   = !cur_valid_reg || (cur_slot_reg != best_idx) ||
                  ((quantum_reg != 16'd0) && (qcount_reg >= quantum_reg));
        rem_dec = (best.entry.remaining != 16'd0) ? (best.entry.remaining - 16'd1)
                                                  : best.entry.remaining;
        qc_base = slice ? 16'd0 : qcount_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        cur_slot_next  = cur_slot_reg;
        cur_valid_next = cur_valid_reg;
        qcount_next    = qcount_reg;
        tick_next      = tick_reg;
        scan_next      = scan_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_tick_next    = o_tick_reg;
        o_run_next     = o_run_reg;
        o_slot_next    = o_slot_reg;
        o_first_next   = o_first_reg;
        o_slice_next   = o_slice_reg;
        o_fin_next     = o_fin_reg;
        o_done_next    = o_done_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = ld_idx;
        mem_wdata      = '0;

        case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    scan_next  = '0;
                    state_next = (operation == pps_pkg::OP_TICK) ? pps_pkg::ST_SCAN
                                                                 : pps_pkg::ST_LOAD;
                end
            end

            pps_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    if (ld_in_range)
                    begin
                        mem_we            = 1'b1;
                        mem_waddr         = ld_idx;
                        mem_wdata.arrival   = arrival_reg;
                        mem_wdata.prio      = prio_reg;
                        mem_wdata.remaining = duration_reg;
                        mem_wdata.started   = 1'b0;
                        pend_next[ld_idx] = (duration_reg != 16'd0);
                        if (cur_valid_reg && (cur_slot_reg == ld_idx))
                        begin
                            cur_valid_next = 1'b0;
                            qcount_next    = 16'd0;
                        end
                    end
                    o_tick_next    = tick_reg;
                    o_run_next     = 1'b0;
                    o_slot_next    = 4'd0;
                    o_first_next   = 1'b0;
                    o_slice_next   = 1'b0;
                    o_fin_next     = 1'b0;
                    o_done_next    = ~|pend_next;
                    out_valid_next = 1'b1;
                    state_next     = pps_pkg::ST_IDLE;
                end
            end

            pps_pkg::ST_SCAN:
            begin
                mem_re = 1'b1;
                if (scan_reg == LAST_SLOT)
                begin
                    state_next = pps_pkg::ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            pps_pkg::ST_DRAIN:
            begin
                state_next = pps_pkg::ST_EXEC;
            end

            pps_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    o_tick_next  = tick_reg;
                    o_run_next   = 1'b0;
                    o_slot_next  = 4'd0;
                    o_first_next = 1'b0;
                    o_slice_next = 1'b0;
                    o_fin_next   = 1'b0;
                    if (best.found)
                    begin
                        mem_we              = 1'b1;
                        mem_waddr           = best_idx;
                        mem_wdata           = best.entry;
                        mem_wdata.started   = 1'b1;
                        mem_wdata.remaining = rem_dec;
                        o_run_next   = 1'b1;
                        o_slot_next  = 4'(best_idx);
                        o_first_next = !best.entry.started;
                        o_slice_next = slice;
                        if (rem_dec == 16'd0)
                        begin
                            o_fin_next          = 1'b1;
                            pend_next[best_idx] = 1'b0;
                            qcount_next         = 16'd0;
                            cur_valid_next      = 1'b0;
                            cur_slot_next       = best_idx;
                        end
                        else
                        begin
                            qcount_next    = (qc_base != 16'hFFFF) ? (qc_base + 16'd1) : qc_base;
                            cur_valid_next = 1'b1;
                            cur_slot_next  = best_idx;
                        end
                    end
                    if (tick_reg != 32'hFFFF_FFFF)
                    begin
                        tick_next = tick_reg + 32'd1;
                    end
                    o_done_next    = ~|pend_next;
                    out_valid_next = 1'b1;
                    state_next     = pps_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pps_pkg::ST_IDLE;
            pend_reg      <= '0;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            qcount_reg    <= 16'd0;
            tick_reg      <= 32'd0;
            quantum_reg   <= 16'd0;
            scan_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            qcount_reg    <= qcount_next;
            tick_reg      <= tick_next;
            scan_reg      <= scan_next;
            rd_vld_reg    <= mem_re;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                quantum_reg <= cfg_wdata;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg     <= slot;
            arrival_reg  <= arrival;
            duration_reg <= duration;
            prio_reg     <= priority_req;
        end
        o_tick_reg  <= o_tick_next;
        o_run_reg   <= o_run_next;
        o_slot_reg  <= o_slot_next;
        o_first_reg <= o_first_next;
        o_slice_reg <= o_slice_next;
        o_fin_reg   <= o_fin_next;
        o_done_reg  <= o_done_next;
    end

    // slot memory, one write and one registered read per cycle; reads and
    // writes never overlap since a beat is scanned before it writes back
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[scan_reg];
            rd_idx_reg  <= scan_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tick_now      = o_tick_reg;
    assign running_valid = o_run_reg;
    assign running_slot  = o_slot_reg;
    assign first_run     = o_first_reg;
    assign new_slice     = o_slice_reg;
    assign finished      = o_fin_reg;
    assign all_done      = o_done_reg;

endmodule

FILE: hdl/pps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks for the preemptive priority scheduler, bound to the top.
// ----------------------------------------------------------------------------
module pps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] tick_now,
    input logic        running_valid,
    input logic        first_run,
    input logic        new_slice,
    input logic        finished
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tick_now) && $stable(running_valid))
        else $error("result beat changed while stalled");

    // idle ticks and load results carry no run flags
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running_valid |-> !first_run && !new_slice && !finished)
        else $error("run flags set without a running task");

    // a task never run before cannot already be current
    a_first_slice: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_run |-> new_slice)
        else $error("first run without a new slice");

    // tick never moves backward between delivered beats
    a_tick_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid |-> tick_now >= $past(tick_now))
        else $error("tick went backward");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tick_now      (tick_now),
    .running_valid (running_valid),
    .first_run     (first_run),
    .new_slice     (new_slice),
    .finished      (finished)
);
